>>> hw/rtl/modexp_pkg.sv
// Shared widths and sequencer state type for the modular exponentiation block.
package modexp_pkg;

    // Significant bits of every operand and of the result
    localparam int OPERAND_WIDTH = 31;
    // Step counter width for one bit-serial modular multiply
    localparam int CNT_W = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;
    // Width of one multiply step sum (2r + a stays below 3m)
    localparam int SUM_W = OPERAND_WIDTH + 2;

    typedef logic [OPERAND_WIDTH-1:0] operand_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } state_t;

endpackage

>>> hw/rtl/modular_exponentiation.sv
// Top level: right-to-left square-and-multiply modular exponentiation.
//
// One request computes base_value ** exponent mod modulus. A single shared
// bit-serial modular multiplier (shift, add, and reduce by m or 2m, one
// multiplier bit per cycle) does all the work, so every modular multiply
// walks through all OPERAND_WIDTH bits of its multiplier. The base is first
// reduced with one pass of that unit, then each set exponent bit costs one
// multiply and each bit below the highest set one costs one squaring;
// scanning stops after the highest set exponent bit. A zero modulus
// (flagged on bad_modulus, result 0) or a zero exponent (result 1) skips
// the multiplier and goes straight to the done state. in_ready is high
// only while the unit is idle; a finished result waits in an output
// register, so a new request can be taken while the previous result is
// still pending.
module modular_exponentiation (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [modexp_pkg::OPERAND_WIDTH-1:0] base_value,
    input  logic [modexp_pkg::OPERAND_WIDTH-1:0] exponent,
    input  logic [modexp_pkg::OPERAND_WIDTH-1:0] modulus,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [modexp_pkg::OPERAND_WIDTH-1:0] power_result,
    output logic                             bad_modulus
);
    import modexp_pkg::*;

    state_t            state_reg, state_next;
    operand_t          acc_reg, acc_next;
    operand_t          sq_reg, sq_next;
    operand_t          exp_reg, exp_next;
    operand_t          mod_reg, mod_next;
    operand_t          op_a_reg, op_a_next;
    operand_t          op_b_reg, op_b_next;
    operand_t          part_reg, part_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              bad_reg, bad_next;
    logic              out_valid_reg, out_valid_next;
    operand_t          power_result_reg, power_result_next;
    logic              bad_modulus_reg, bad_modulus_next;

    logic              in_fire;
    logic              op_last;
    logic              out_free;
    logic [SUM_W-1:0]  step_add;
    logic [SUM_W-1:0]  step_sum;
    logic [SUM_W:0]    step_sub1;
    logic [SUM_W:0]    step_sub2;
    operand_t          step_res;
    operand_t          sq_new;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign op_last   = (cnt_reg == '0);
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign power_result = power_result_reg;
    assign bad_modulus  = bad_modulus_reg;

    // Shared multiply step: r = 2r + b_msb * a, reduced by m or 2m
    assign step_add  = op_b_reg[OPERAND_WIDTH-1] ? {2'b00, op_a_reg} : '0;
    assign step_sum  = {1'b0, part_reg, 1'b0} + step_add;
    assign step_sub1 = {1'b0, step_sum} - {3'b000, mod_reg};
    assign step_sub2 = {1'b0, step_sum} - {2'b00, mod_reg, 1'b0};

    always_comb
    begin
        if (!step_sub2[SUM_W])
        begin
            step_res = step_sub2[OPERAND_WIDTH-1:0];
        end
        else if (!step_sub1[SUM_W])
        begin
            step_res = step_sub1[OPERAND_WIDTH-1:0];
        end
        else
        begin
            step_res = step_sum[OPERAND_WIDTH-1:0];
        end
    end

    // Running square after this cycle's completion
    assign sq_new = ((state_reg == ST_REDUCE || state_reg == ST_SQR) && op_last)
                    ? step_res : sq_reg;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (modulus == '0 || exponent == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (op_last)
                begin
                    state_next = exp_reg[0] ? ST_MUL : ST_SQR;
                end
            end
            ST_MUL:
            begin
                if (op_last)
                begin
                    state_next = ((exp_reg >> 1) == '0) ? ST_DONE : ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (op_last)
                begin
                    state_next = exp_reg[1] ? ST_MUL : ST_SQR;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output register next values
    always_comb
    begin
        acc_next          = acc_reg;
        sq_next           = sq_reg;
        exp_next          = exp_reg;
        mod_next          = mod_reg;
        op_a_next         = op_a_reg;
        op_b_next         = op_b_reg;
        part_next         = part_reg;
        cnt_next          = cnt_reg;
        bad_next          = bad_reg;
        out_valid_next    = out_valid_reg;
        power_result_next = power_result_reg;
        bad_modulus_next  = bad_modulus_reg;

        // Drain the output register
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    mod_next  = modulus;
                    exp_next  = exponent;
                    bad_next  = (modulus == '0);
                    acc_next  = (modulus == '0) ? '0 : OPERAND_WIDTH'(1);
                    // Base reduction runs as 1 * base mod m
                    op_a_next = OPERAND_WIDTH'(1);
                    op_b_next = base_value;
                    part_next = '0;
                    cnt_next  = CNT_W'(OPERAND_WIDTH - 1);
                end
            end
            ST_REDUCE, ST_MUL, ST_SQR:
            begin
                part_next = step_res;
                op_b_next = op_b_reg << 1;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (op_last)
                begin
                    sq_next = sq_new;
                    if (state_reg == ST_MUL)
                    begin
                        acc_next = step_res;
                    end
                    if (state_reg == ST_SQR)
                    begin
                        exp_next = exp_reg >> 1;
                    end
                    // Load the operands of the next multiply
                    part_next = '0;
                    cnt_next  = CNT_W'(OPERAND_WIDTH - 1);
                    op_a_next = sq_new;
                    if (state_next == ST_MUL)
                    begin
                        op_b_next = acc_reg;
                    end
                    else
                    begin
                        op_b_next = sq_new;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    power_result_next = acc_reg;
                    bad_modulus_next  = bad_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        acc_reg          <= acc_next;
        sq_reg           <= sq_next;
        exp_reg          <= exp_next;
        mod_reg          <= mod_next;
        op_a_reg         <= op_a_next;
        op_b_reg         <= op_b_next;
        part_reg         <= part_next;
        cnt_reg          <= cnt_next;
        bad_reg          <= bad_next;
        power_result_reg <= power_result_next;
        bad_modulus_reg  <= bad_modulus_next;
    end

endmodule

>>> hw/rtl/modexp_checker.sv
// Port-level checks for the modular exponentiation block, bound to the top level.
module modexp_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic [modexp_pkg::OPERAND_WIDTH-1:0]  modulus,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic [modexp_pkg::OPERAND_WIDTH-1:0]  power_result,
    input logic                                  bad_modulus
);

    // Unit is busy right after taking a request
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after a request was taken");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(power_result) && $stable(bad_modulus)))
    else $error("stalled result changed or dropped");

    // Flagged modulus always comes with a zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_modulus) |-> (power_result == '0))
    else $error("bad_modulus set with nonzero result");

    // Zero modulus shortcut presents a result on out_valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && modulus == '0) |-> ##2 out_valid)
    else $error("zero modulus request did not complete promptly");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (.*);
